// ===== design/fts_pkg.sv =====
// Shared types, constants and table functions for the fan thermal supervisor.
`default_nettype none
package fts_pkg;

  typedef struct packed {
    logic signed [11:0] ambient_temp;
    logic signed [11:0] proc_temp;
    logic [15:0]        tach_rpm;
  } fts_in_t;

  typedef struct packed {
    logic [7:0]  pwm_duty;
    logic [6:0]  duty_pct;
    logic [15:0] reported_rpm;
    logic        alarm_on;
    logic [1:0]  alarm_kind;
    logic [1:0]  alarm_notice;
    logic        sync_send;
  } fts_out_t;

  typedef enum logic [1:0] {
    REG_MANUAL_MODE  = 2'd0,
    REG_MANUAL_DUTY  = 2'd1,
    REG_ALARM_THR    = 2'd2,
    REG_TACH_PRESENT = 2'd3
  } fts_reg_t;

  typedef enum logic [1:0] {
    KIND_NONE   = 2'd0,
    KIND_STALL  = 2'd1,
    KIND_SENSOR = 2'd2,
    KIND_HOT    = 2'd3
  } fts_kind_t;

  typedef enum logic [1:0] {
    NOTICE_NONE    = 2'd0,
    NOTICE_RAISED  = 2'd1,
    NOTICE_REPEAT  = 2'd2,
    NOTICE_CLEARED = 2'd3
  } fts_notice_t;

  // Fan drive result passed from the duty logic to the alarm logic.
  typedef struct packed {
    logic [7:0]  pwm;
    logic [6:0]  pct;
    logic [15:0] rpm;
    logic        run;
  } fts_duty_t;

  typedef struct packed {
    logic        alarm_on;
    fts_kind_t   kind;
    fts_notice_t notice;
  } fts_alarm_t;

  localparam logic [6:0]  PCT_MAX    = 7'd100;
  localparam logic [7:0]  PWM_RUN    = 8'd100;
  localparam logic [7:0]  PWM_FAIL   = 8'd200;
  localparam logic [15:0] RPM_PER_PCT = 16'd45;
  // 255 * round(2^19 / 100): pct * 255 / 100 as one multiply and shift
  localparam logic [20:0] PWM_RECIP  = 21'd1336965;
  localparam int          PWM_SHIFT  = 19;

  localparam logic signed [11:0] HOT_AMBIENT = 12'sd400;
  localparam logic signed [11:0] HOT_CPU     = 12'sd750;

  localparam logic signed [11:0] AMB_STEP0 = 12'sd260;
  localparam logic signed [11:0] AMB_STEP1 = 12'sd290;
  localparam logic signed [11:0] AMB_STEP2 = 12'sd330;
  localparam logic signed [11:0] AMB_STEP3 = 12'sd370;
  localparam logic signed [11:0] CPU_STEP0 = 12'sd500;
  localparam logic signed [11:0] CPU_STEP1 = 12'sd600;
  localparam logic signed [11:0] CPU_STEP2 = 12'sd750;

  function automatic logic [7:0] amb_level(input logic signed [11:0] t);
    logic [7:0] lvl;
    if (t < AMB_STEP0)      lvl = 8'd0;
    else if (t < AMB_STEP1) lvl = 8'd100;
    else if (t < AMB_STEP2) lvl = 8'd150;
    else if (t < AMB_STEP3) lvl = 8'd200;
    else                    lvl = 8'd255;
    return lvl;
  endfunction

  function automatic logic [7:0] cpu_level(input logic signed [11:0] t);
    logic [7:0] lvl;
    if (t < CPU_STEP0)      lvl = 8'd0;
    else if (t < CPU_STEP1) lvl = 8'd150;
    else if (t < CPU_STEP2) lvl = 8'd200;
    else                    lvl = 8'd255;
    return lvl;
  endfunction

  // pwm * 100 / 255, truncated, for the table levels
  function automatic logic [6:0] auto_pct(input logic [7:0] pwm);
    logic [6:0] pct;
    case (pwm)
      8'd100:  pct = 7'd39;
      8'd150:  pct = 7'd58;
      8'd200:  pct = 7'd78;
      8'd255:  pct = 7'd100;
      default: pct = 7'd0;
    endcase
    return pct;
  endfunction

endpackage
`default_nettype wire

// ===== design/fts_duty.sv =====
// Fan duty selection: manual or table-driven pwm, percent and reported rpm.
`default_nettype none
module fts_duty (
  input  wire logic                     manual_mode,
  input  wire logic [6:0]               manual_duty_pct,
  input  wire logic                     tach_present,
  input  wire fts_pkg::fts_in_t         tick,
  output fts_pkg::fts_duty_t            duty
);
  import fts_pkg::*;

  logic [6:0]  man_pct;
  logic [27:0] man_prod;
  logic [7:0]  man_pwm;
  logic [7:0]  amb_pwm;
  logic [7:0]  cpu_pwm;
  logic [7:0]  auto_pwm;
  logic [7:0]  pwm;
  logic [6:0]  pct;

  always_comb begin
    man_pct  = (manual_duty_pct > PCT_MAX) ? PCT_MAX : manual_duty_pct;
    man_prod = 28'(man_pct) * 28'(PWM_RECIP);
    man_pwm  = man_prod[PWM_SHIFT +: 8];

    // An ambient reading that is not positive drives the fan hard
    amb_pwm  = (tick.ambient_temp > 12'sd0) ? amb_level(tick.ambient_temp) : PWM_FAIL;
    cpu_pwm  = (tick.proc_temp > 12'sd0) ? cpu_level(tick.proc_temp) : 8'd0;
    auto_pwm = (cpu_pwm > amb_pwm) ? cpu_pwm : amb_pwm;

    pwm = manual_mode ? man_pwm : auto_pwm;
    pct = manual_mode ? man_pct : auto_pct(auto_pwm);

    duty.pwm = pwm;
    duty.pct = pct;
    duty.rpm = tach_present ? tick.tach_rpm : 16'(16'(pct) * RPM_PER_PCT);
    duty.run = (pwm >= PWM_RUN);
  end

endmodule
`default_nettype wire

// ===== design/fts_alarm.sv =====
// Spin-up grace, stall counting and alarm priority with notice tracking.
`default_nettype none
module fts_alarm #(
  parameter int unsigned GRACE_TICKS = 3
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     step,
  input  wire logic                     tach_present,
  input  wire logic signed [11:0]       alarm_threshold,
  input  wire logic signed [11:0]       ambient_temp,
  input  wire logic signed [11:0]       proc_temp,
  input  wire fts_pkg::fts_duty_t       duty,
  output fts_pkg::fts_alarm_t           alarm
);
  import fts_pkg::*;

  localparam int GW = $clog2(GRACE_TICKS + 1);
  localparam logic [GW-1:0] GRACE_LOAD = GW'(GRACE_TICKS);

  logic            first_tick;
  logic            fan_was_running;
  logic [GW-1:0]   grace_left;
  logic [1:0]      zero_rpm_ticks;
  logic            prev_alarm_on;
  fts_kind_t       prev_alarm_kind;
  logic            heartbeat_count;

  logic [GW-1:0]   grace_mid;
  logic [GW-1:0]   grace_left_next;
  logic [1:0]      zero_rpm_ticks_next;
  logic            heartbeat_count_next;
  logic            stalled;
  logic            hot;
  fts_kind_t       kind;
  fts_notice_t     notice;

  always_comb begin
    grace_mid = grace_left;
    if (first_tick) begin
      if (duty.run && tach_present && (duty.rpm != 16'd0)) begin
        grace_mid = '0;
      end else if (duty.run) begin
        grace_mid = GRACE_LOAD;
      end
    end else begin
      if (duty.run && !fan_was_running) grace_mid = GRACE_LOAD;
      if (!duty.run) grace_mid = '0;
    end

    grace_left_next     = grace_mid;
    zero_rpm_ticks_next = 2'd0;
    stalled             = 1'b0;
    if (tach_present && duty.run) begin
      if (grace_mid != '0) begin
        grace_left_next = grace_mid - GW'(1);
      end else if (duty.rpm == 16'd0) begin
        // saturate at three
        zero_rpm_ticks_next = (zero_rpm_ticks == 2'd3) ? 2'd3 : zero_rpm_ticks + 2'd1;
        stalled = (zero_rpm_ticks_next >= 2'd2);
      end
    end

    hot = (ambient_temp > HOT_AMBIENT) || (ambient_temp >= alarm_threshold) ||
          (proc_temp >= HOT_CPU);
    if (stalled)                    kind = KIND_STALL;
    else if (ambient_temp < 12'sd0) kind = KIND_SENSOR;
    else if (hot)                   kind = KIND_HOT;
    else                            kind = KIND_NONE;

    notice               = NOTICE_NONE;
    heartbeat_count_next = heartbeat_count;
    if (kind != KIND_NONE) begin
      if (!prev_alarm_on || (prev_alarm_kind != kind)) begin
        notice               = NOTICE_RAISED;
        heartbeat_count_next = 1'b0;
      end else if (heartbeat_count) begin
        notice               = NOTICE_REPEAT;
        heartbeat_count_next = 1'b0;
      end else begin
        heartbeat_count_next = 1'b1;
      end
    end else if (prev_alarm_on) begin
      notice = NOTICE_CLEARED;
    end

    alarm.alarm_on = (kind != KIND_NONE);
    alarm.kind     = kind;
    alarm.notice   = notice;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      first_tick      <= 1'b1;
      fan_was_running <= 1'b0;
      grace_left      <= '0;
      zero_rpm_ticks  <= 2'd0;
      prev_alarm_on   <= 1'b0;
      prev_alarm_kind <= KIND_NONE;
      heartbeat_count <= 1'b0;
    end else if (step) begin
      first_tick      <= 1'b0;
      fan_was_running <= duty.run;
      grace_left      <= grace_left_next;
      zero_rpm_ticks  <= zero_rpm_ticks_next;
      prev_alarm_on   <= (kind != KIND_NONE);
      prev_alarm_kind <= kind;
      heartbeat_count <= heartbeat_count_next;
    end
  end

endmodule
`default_nettype wire

// ===== design/fan_thermal_supervisor.sv =====
// Fan thermal supervisor top level: config registers, input and result registers.
// An accepted item is held in the input register; the duty and alarm logic work on it
// combinationally and the result register captures the outcome, raising out_valid.
// Throughput: one item per cycle unless out_stall holds a full result register; the
// input and result registers form a two-stage pipeline with a single pass of logic between.
// Reset clears both stage valid flags and the tick history; config returns to its reset values.
`default_nettype none
module fan_thermal_supervisor #(
  parameter int unsigned GRACE_TICKS = 3
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_we,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [11:0]       cfg_wdata,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire fts_pkg::fts_in_t  in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output fts_pkg::fts_out_t      out_data
);
  import fts_pkg::*;

  logic              manual_mode;
  logic [6:0]        manual_duty_pct;
  logic signed [11:0] alarm_threshold;
  logic              tach_present;

  logic              tick_valid;
  fts_in_t           tick;
  logic              out_open;
  logic              advance;
  fts_duty_t         duty;
  fts_alarm_t        alarm;
  fts_out_t          result;

  always_ff @(posedge clk) begin
    if (rst) begin
      manual_mode     <= 1'b0;
      manual_duty_pct <= 7'd0;
      alarm_threshold <= 12'sd400;
      tach_present    <= 1'b1;
    end else if (cfg_we) begin
      unique case (fts_reg_t'(cfg_index))
        REG_MANUAL_MODE:  manual_mode     <= cfg_wdata[0];
        REG_MANUAL_DUTY:  manual_duty_pct <= cfg_wdata[6:0];
        REG_ALARM_THR:    alarm_threshold <= $signed(cfg_wdata);
        REG_TACH_PRESENT: tach_present    <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign out_open = !out_valid || !out_stall;
  assign advance  = tick_valid && out_open;
  assign in_stall = tick_valid && !out_open;

  // Input stage: load whenever the held item moves on or the stage is empty
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_valid <= 1'b0;
    end else if (!in_stall) begin
      tick_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) tick <= in_data;
  end

  fts_duty u_duty (
    .manual_mode     (manual_mode),
    .manual_duty_pct (manual_duty_pct),
    .tach_present    (tach_present),
    .tick            (tick),
    .duty            (duty)
  );

  fts_alarm #(
    .GRACE_TICKS (GRACE_TICKS)
  ) u_alarm (
    .clk             (clk),
    .rst             (rst),
    .step            (advance),
    .tach_present    (tach_present),
    .alarm_threshold (alarm_threshold),
    .ambient_temp    (tick.ambient_temp),
    .proc_temp       (tick.proc_temp),
    .duty            (duty),
    .alarm           (alarm)
  );

  always_comb begin
    result.pwm_duty     = duty.pwm;
    result.duty_pct     = duty.pct;
    result.reported_rpm = duty.rpm;
    result.alarm_on     = alarm.alarm_on;
    result.alarm_kind   = alarm.kind;
    result.alarm_notice = alarm.notice;
    result.sync_send    = !alarm.alarm_on;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_open) begin
      out_valid <= tick_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) out_data <= result;
  end

endmodule
`default_nettype wire
